// ===== rtl/core/tte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg
// Codes, character constants and port widths shared by the terminal cell
// engine modules.
// ----------------------------------------------------------------------------
package tte_pkg;

  // item kinds, carried on s_tuser
  localparam logic [3:0] KIND_WRITE   = 4'd0;
  localparam logic [3:0] KIND_BACK    = 4'd1;
  localparam logic [3:0] KIND_DELWORD = 4'd2;
  localparam logic [3:0] KIND_SCROLL  = 4'd3;
  localparam logic [3:0] KIND_MOVEABS = 4'd4;
  localparam logic [3:0] KIND_MOVEREL = 4'd5;
  localparam logic [3:0] KIND_ERASED  = 4'd6;
  localparam logic [3:0] KIND_ERASEL  = 4'd7;
  localparam logic [3:0] KIND_OFFSET  = 4'd8;
  localparam logic [3:0] KIND_RESET   = 4'd9;
  localparam logic [3:0] KIND_READ    = 4'd10;

  // erase modes
  localparam logic [1:0] ERASE_TO_END   = 2'd0;
  localparam logic [1:0] ERASE_TO_CUR   = 2'd1;
  localparam logic [1:0] ERASE_ALL      = 2'd2;
  localparam logic [1:0] ERASE_RESET    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_TAB   = 2'd2;
  localparam logic [1:0] CFG_COLOR = 2'd3;

  // register reset values
  localparam logic [5:0] RST_ROWS  = 6'd25;
  localparam logic [7:0] RST_COLS  = 8'd80;
  localparam logic [4:0] RST_TAB   = 5'd8;
  localparam logic [7:0] RST_COLOR = 8'd7;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;
  localparam int KIND_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

endpackage

// ===== rtl/core/text_terminal_cell_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cell_engine_top
// Character-cell terminal with scrollback over a ring of 16-bit cells.
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer around a single-port cell
// memory and a tab mark memory. A plain character passes through accept,
// dispatch, address, cell write and result; a carriage return or a newline
// above the bottom row skips the cell write, a cursor move, offset or view
// scroll the address too. Whenever the view has moved or the row count was
// reconfigured, the next item that touches the cells first uses the bit-serial
// remainder unit to place the view in the ring; a tab uses the same unit.
// Scrolling at the bottom row clears the new row at one cell a cycle, erases
// run at one cell a cycle between rows, backspace over a tab steps back through
// a loop and a check state per column. After reset, and for a reset item,
// the MAX_ROWS*MAX_COLS tab marks (4096 by default) are cleared in a pass
// that takes no item; configuration writes are always taken. A reset item
// must be issued before anything is read from the cell store.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine_top import tte_pkg::*; #(
  parameter int MAX_ROWS       = 32,
  parameter int MAX_COLS       = 128,
  parameter int HISTORY_FACTOR = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // char_code, color, target_row, target_col, delta_row, delta_col,
  // scroll_lines, scroll_down, erase_mode, col_offset, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cursor_row, cursor_col, view_at_bottom, lines_scrolled_back, cell_value,
  // zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int RING_W  = $clog2(MAX_ROWS * HISTORY_FACTOR + 1);
  localparam int DEN_W   = (RING_W > 5) ? RING_W : 5;
  localparam int CELL_N  = MAX_ROWS * HISTORY_FACTOR * MAX_COLS;
  localparam int CELL_AW = $clog2(CELL_N);
  localparam int MARK_N  = MAX_ROWS * MAX_COLS;
  localparam int MARK_AW = $clog2(MARK_N);

  logic               mod_start;
  logic [31:0]        mod_num;
  logic [DEN_W-1:0]   mod_den;
  logic               mod_done;
  logic [DEN_W-1:0]   mod_rem;
  logic               cell_we;
  logic [CELL_AW-1:0] cell_addr;
  logic [15:0]        cell_wdata;
  logic [15:0]        cell_rdata;
  logic               tab_we;
  logic [MARK_AW-1:0] tab_addr;
  logic               tab_wdata;
  logic               tab_rdata;

  // sequencer
  tte_ctrl #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HISTORY_FACTOR(HISTORY_FACTOR),
    .DEN_W(DEN_W), .CELL_AW(CELL_AW), .MARK_AW(MARK_AW)
  ) u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .mod_start, .mod_num, .mod_den, .mod_done, .mod_rem,
    .cell_we, .cell_addr, .cell_wdata, .cell_rdata,
    .tab_we, .tab_addr, .tab_wdata, .tab_rdata
  );

  // ring position and tab stop remainders
  tte_mod #(.DEN_W(DEN_W)) u_mod (
    .clk, .rst, .start(mod_start), .num(mod_num), .den(mod_den),
    .done(mod_done), .rem(mod_rem)
  );

  // cell store
  tte_ram #(.WIDTH(16), .DEPTH(CELL_N), .AW(CELL_AW)) u_cells (
    .clk, .we(cell_we), .addr(cell_addr), .wdata(cell_wdata), .rdata(cell_rdata)
  );

  // tab marks
  tte_ram #(.WIDTH(1), .DEPTH(MARK_N), .AW(MARK_AW)) u_marks (
    .clk, .we(tab_we), .addr(tab_addr), .wdata(tab_wdata), .rdata(tab_rdata)
  );

endmodule

// ===== rtl/core/tte_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_ram
// Single-port synchronous memory, one write or read per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/tte_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_mod
// Restoring remainder unit: 32-bit numerator modulo a narrow divisor, one
// numerator bit per cycle.
// ----------------------------------------------------------------------------
module tte_mod #(
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DEN_W-1:0] rem
);

  logic             busy;
  logic [4:0]       cnt;
  logic [31:0]      numsh;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   part;
  logic [DEN_W:0]   trial;

  // shift in the next numerator bit
  always_comb begin
    trial = {rem, numsh[31]};
  end

  always_comb begin
    part = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        numsh <= num;
        den_q <= den;
        rem   <= '0;
      end else if (busy) begin
        rem   <= part[DEN_W-1:0];
        numsh <= {numsh[30:0], 1'b0};
        cnt   <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/tte_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_ctrl
// Item sequencer of the terminal: cursor and view registers, cell and tab
// mark accesses, row sweeps and the result register.
// ----------------------------------------------------------------------------
module tte_ctrl import tte_pkg::*; #(
  parameter int MAX_ROWS       = 32,
  parameter int MAX_COLS       = 128,
  parameter int HISTORY_FACTOR = 10,
  parameter int DEN_W          = 11,
  parameter int CELL_AW        = 16,
  parameter int MARK_AW        = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // items in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  // results out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // remainder unit
  output logic                  mod_start,
  output logic [31:0]           mod_num,
  output logic [DEN_W-1:0]      mod_den,
  input  logic                  mod_done,
  input  logic [DEN_W-1:0]      mod_rem,
  // cell store
  output logic                  cell_we,
  output logic [CELL_AW-1:0]    cell_addr,
  output logic [15:0]           cell_wdata,
  input  logic [15:0]           cell_rdata,
  // tab marks
  output logic                  tab_we,
  output logic [MARK_AW-1:0]    tab_addr,
  output logic                  tab_wdata,
  input  logic                  tab_rdata
);

  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int RING_W = $clog2(MAX_ROWS * HISTORY_FACTOR + 1);
  localparam int MARK_N = MAX_ROWS * MAX_COLS;

  typedef enum logic [4:0] {
    S_TCLR, S_IDLE, S_DISP, S_MSTART, S_MOD, S_EXEC, S_PUT, S_SWEEP,
    S_TSTART, S_TMOD, S_TABW, S_BS0, S_BS_RD, S_BS_CHK, S_BS_LP, S_BS_LPC,
    S_DW, S_DW_C, S_RD, S_RDC, S_DONE
  } state_t;

  state_t state;
  state_t sw_ret;

  // configuration registers
  logic [5:0] vis_rows;
  logic [7:0] vis_cols;
  logic [4:0] tab_width;
  logic [7:0] def_color;

  // terminal state
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [6:0]        left_limit;
  logic [31:0]       view_pos;
  logic [31:0]       newest_pos;
  logic [RING_W-1:0] base;
  logic              base_ok;

  // latched item
  logic [3:0]  kind;
  logic [7:0]  ch;
  logic [7:0]  color;
  logic [7:0]  trow;
  logic [7:0]  tcol;
  logic signed [7:0] drow;
  logic signed [7:0] dcol;
  logic [15:0] lines;
  logic        down;
  logic [1:0]  mode;
  logic [6:0]  offset;

  // sweep and loop registers
  logic [ROW_W-1:0]   sw_row;
  logic [COL_W-1:0]   sw_col;
  logic [ROW_W-1:0]   sw_erow;
  logic [COL_W-1:0]   sw_ecol;
  logic [7:0]         sw_color;
  logic [MARK_AW-1:0] tclr_cnt;
  logic               tclr_item;
  logic [4:0]         bs_cnt;
  logic               dw_on;
  logic               dw_two;
  logic [15:0]        cell_val;

  // derived values
  logic [ROW_W-1:0]  rows_n;
  logic [COL_W-1:0]  cols_n;
  logic [4:0]        tab_n;
  logic [RING_W-1:0] ring_n;
  logic [ROW_W-1:0]  row_clamp;
  logic [COL_W-1:0]  col_clamp;
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic [RING_W:0]   ring_sum;
  logic [RING_W:0]   ring;
  logic [RING_W:0]   base_inc;
  logic              sw_end;
  logic              need_base;
  logic              do_reset;
  logic              is_nl;
  logic              wrap;
  logic [9:0]        tab_sum;
  logic [COL_W-1:0]  tab_stop;
  logic [31:0]       extra;
  logic [31:0]       lo;
  logic [32:0]       req;
  logic [31:0]       view_new;
  logic signed [9:0]  rel_row;
  logic signed [10:0] rel_col;
  logic [ROW_W-1:0]  rel_row_cl;
  logic [COL_W-1:0]  rel_col_cl;
  logic [31:0]       back_diff;
  logic [8:0]        back_sat;
  state_t            bs_ret;

  function automatic logic [ROW_W-1:0] clamp_rows(input logic [5:0] v);
    logic [ROW_W-1:0] r;
    if (v == 6'd0) r = ROW_W'(1);
    else if (32'(v) > MAX_ROWS) r = ROW_W'(MAX_ROWS);
    else r = ROW_W'(v);
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_cols(input logic [7:0] v);
    logic [COL_W-1:0] c;
    if (v < 8'd2) c = COL_W'(2);
    else if (32'(v) > MAX_COLS) c = COL_W'(MAX_COLS);
    else c = COL_W'(v);
    return c;
  endfunction

  // screen geometry in use
  always_comb begin
    rows_n = clamp_rows(vis_rows);
    cols_n = clamp_cols(vis_cols);
    tab_n  = (tab_width == 5'd0) ? 5'd1 : tab_width;
    ring_n = RING_W'(32'(rows_n) * HISTORY_FACTOR);
  end

  // clamped absolute target
  always_comb begin
    row_clamp = (9'(trow) > 9'(rows_n) - 9'd1) ? rows_n - ROW_W'(1) : ROW_W'(trow);
    col_clamp = (9'(tcol) > 9'(cols_n) - 9'd1) ? cols_n - COL_W'(1) : COL_W'(tcol);
  end

  // clamped relative move
  always_comb begin
    rel_row = $signed(10'(cur_row)) + 10'(drow);
    rel_col = $signed(11'(cur_col)) + 11'(dcol);
    if (rel_row < 0) rel_row_cl = '0;
    else if (rel_row > $signed(10'(rows_n)) - 10'sd1) rel_row_cl = rows_n - ROW_W'(1);
    else rel_row_cl = ROW_W'(rel_row);
    if (rel_col < 0) rel_col_cl = '0;
    else if (rel_col > $signed(11'(cols_n)) - 11'sd1) rel_col_cl = cols_n - COL_W'(1);
    else rel_col_cl = COL_W'(rel_col);
  end

  // bounded view scroll
  always_comb begin
    extra = 32'(32'(rows_n) * (HISTORY_FACTOR - 1));
    lo    = (newest_pos > extra) ? newest_pos - extra : 32'd0;
    if (down) req = {1'b0, view_pos} + 33'(lines);
    else if (32'(lines) > view_pos) req = '0;
    else req = {1'b0, view_pos - 32'(lines)};
    if (req < {1'b0, lo}) view_new = lo;
    else if (req > {1'b0, newest_pos}) view_new = newest_pos;
    else view_new = req[31:0];
  end

  // kind decode
  always_comb begin
    case (kind) inside
      KIND_WRITE, KIND_BACK, KIND_DELWORD, KIND_ERASED, KIND_ERASEL, KIND_READ:
        need_base = 1'b1;
      default: need_base = 1'b0;
    endcase
    do_reset = (kind == KIND_RESET) || (kind == KIND_ERASED && mode == ERASE_RESET);
    is_nl    = (ch == CH_NL);
    wrap     = (ch != CH_NL) && (ch != CH_CR) && (ch != CH_TAB) && (cur_col >= cols_n);
  end

  // tab stop from the remainder of cur_col + 1
  always_comb begin
    tab_sum = 10'(cur_col) + 10'd1
            + ((mod_rem[4:0] == 5'd0) ? 10'd0 : 10'(tab_n) - 10'(mod_rem[4:0]));
    tab_stop = (tab_sum > 10'(cols_n) - 10'd1) ? cols_n - COL_W'(1) : COL_W'(tab_sum);
  end

  always_comb begin
    base_inc = (RING_W + 1)'(base) + (RING_W + 1)'(1);
    if (base_inc == (RING_W + 1)'(ring_n)) base_inc = '0;
    sw_end = (sw_row > sw_erow) || (sw_row == sw_erow && sw_col >= sw_ecol);
    bs_ret = dw_on ? S_DW : S_DONE;
  end

  // result fields
  always_comb begin
    back_diff = newest_pos - view_pos;
    back_sat  = (back_diff > 32'd511) ? 9'd511 : back_diff[8:0];
  end

  // memory access position
  always_comb begin
    a_row = cur_row;
    a_col = cur_col;
    unique case (state)
      S_SWEEP, S_RD:          begin a_row = sw_row; a_col = sw_col; end
      S_BS_LP, S_DW, S_TABW:  a_col = cur_col - COL_W'(1);
      default: ;
    endcase
  end

  // ring address and memory controls
  always_comb begin
    ring_sum   = (RING_W + 1)'(base) + (RING_W + 1)'(a_row);
    ring       = (ring_sum >= (RING_W + 1)'(ring_n)) ? ring_sum - (RING_W + 1)'(ring_n)
                                                      : ring_sum;
    cell_addr  = CELL_AW'(ring * MAX_COLS) + CELL_AW'(a_col);
    cell_we    = 1'b0;
    cell_wdata = {color, CH_SPACE};
    tab_addr   = MARK_AW'(32'(a_row) * MAX_COLS + 32'(a_col));
    tab_we     = 1'b0;
    tab_wdata  = 1'b0;
    unique case (state)
      S_PUT: begin
        cell_we    = 1'b1;
        cell_wdata = {color, ch};
      end
      S_SWEEP: begin
        cell_we    = !sw_end && (sw_col < cols_n);
        cell_wdata = {sw_color, CH_SPACE};
      end
      S_BS_CHK: begin
        cell_we = !tab_rdata;
        tab_we  = tab_rdata;
      end
      S_TABW: begin
        tab_we    = 1'b1;
        tab_wdata = 1'b1;
      end
      S_TCLR: begin
        tab_addr = tclr_cnt;
        tab_we   = 1'b1;
      end
      default: ;
    endcase
  end

  // remainder unit requests
  always_comb begin
    mod_start = (state == S_MSTART) || (state == S_TSTART);
    if (state == S_TSTART) begin
      mod_num = 32'(cur_col) + 32'd1;
      mod_den = DEN_W'(tab_n);
    end else begin
      mod_num = view_pos;
      mod_den = DEN_W'(ring_n);
    end
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_TCLR;
      sw_ret     <= S_DONE;
      tclr_cnt   <= '0;
      tclr_item  <= 1'b0;
      vis_rows   <= RST_ROWS;
      vis_cols   <= RST_COLS;
      tab_width  <= RST_TAB;
      def_color  <= RST_COLOR;
      cur_row    <= '0;
      cur_col    <= '0;
      left_limit <= '0;
      view_pos   <= '0;
      newest_pos <= '0;
      base       <= '0;
      base_ok    <= 1'b1;
      dw_on      <= 1'b0;
      dw_two     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_TCLR: begin
          if (tclr_cnt == MARK_AW'(MARK_N - 1)) begin
            state <= tclr_item ? S_SWEEP : S_IDLE;
          end else begin
            tclr_cnt <= tclr_cnt + MARK_AW'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind     <= s_tuser;
            ch       <= s_tdata[7:0];
            color    <= s_tdata[15:8];
            trow     <= s_tdata[23:16];
            tcol     <= s_tdata[31:24];
            drow     <= s_tdata[39:32];
            dcol     <= s_tdata[47:40];
            lines    <= s_tdata[63:48];
            down     <= s_tdata[64];
            mode     <= s_tdata[66:65];
            offset   <= s_tdata[73:67];
            cell_val <= '0;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          if (kind == KIND_WRITE && view_pos != newest_pos) begin
            view_pos <= newest_pos;
            base_ok  <= 1'b0;
            state    <= S_MSTART;
          end else if (need_base) begin
            state <= base_ok ? S_EXEC : S_MSTART;
          end else begin
            state <= S_DONE;
            case (kind)
              KIND_SCROLL: begin
                if (view_new != view_pos) base_ok <= 1'b0;
                view_pos <= view_new;
              end
              KIND_MOVEABS: begin
                cur_row <= row_clamp;
                cur_col <= col_clamp;
              end
              KIND_MOVEREL: begin
                cur_row <= rel_row_cl;
                cur_col <= rel_col_cl;
              end
              KIND_OFFSET: left_limit <= offset;
              KIND_RESET:  state <= S_EXEC;
              default: ;
            endcase
          end
        end
        S_MSTART: state <= S_MOD;
        S_MOD: begin
          if (mod_done) begin
            base    <= RING_W'(mod_rem);
            base_ok <= 1'b1;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state    <= S_DONE;
          sw_color <= def_color;
          sw_ret   <= S_DONE;
          if (do_reset) begin
            cur_row    <= '0;
            cur_col    <= '0;
            view_pos   <= '0;
            newest_pos <= '0;
            base       <= '0;
            base_ok    <= 1'b1;
            sw_row     <= '0;
            sw_col     <= '0;
            sw_erow    <= rows_n - ROW_W'(1);
            sw_ecol    <= cols_n;
            tclr_cnt   <= '0;
            tclr_item  <= 1'b1;
            state      <= S_TCLR;
          end else begin
            case (kind)
              KIND_WRITE: begin
                if (is_nl || wrap) begin
                  if (wrap) cur_col <= '0;
                  left_limit <= '0;
                  if ((ROW_W + 1)'(cur_row) + (ROW_W + 1)'(1) < (ROW_W + 1)'(rows_n)) begin
                    cur_row <= cur_row + ROW_W'(1);
                    state   <= is_nl ? S_DONE : S_PUT;
                  end else begin
                    newest_pos <= newest_pos + 32'd1;
                    view_pos   <= newest_pos + 32'd1;
                    base       <= RING_W'(base_inc);
                    sw_row     <= rows_n - ROW_W'(1);
                    sw_col     <= '0;
                    sw_erow    <= rows_n - ROW_W'(1);
                    sw_ecol    <= cols_n;
                    sw_color   <= color;
                    sw_ret     <= is_nl ? S_DONE : S_PUT;
                    state      <= S_SWEEP;
                  end
                end else if (ch == CH_CR) begin
                  cur_col <= '0;
                end else if (ch == CH_TAB) begin
                  state <= S_TSTART;
                end else begin
                  state <= S_PUT;
                end
              end
              KIND_BACK: begin
                dw_on <= 1'b0;
                state <= S_BS0;
              end
              KIND_DELWORD: begin
                dw_on  <= 1'b1;
                dw_two <= 1'b0;
                state  <= S_DW;
              end
              KIND_ERASED: begin
                state   <= S_SWEEP;
                sw_row  <= '0;
                sw_col  <= '0;
                sw_erow <= rows_n - ROW_W'(1);
                sw_ecol <= cols_n;
                if (mode == ERASE_TO_END) begin
                  sw_row <= cur_row;
                  sw_col <= cur_col;
                end else if (mode == ERASE_TO_CUR) begin
                  sw_erow <= cur_row;
                  sw_ecol <= cur_col;
                end
              end
              KIND_ERASEL: begin
                sw_row  <= cur_row;
                sw_erow <= cur_row;
                sw_col  <= (mode == ERASE_TO_END) ? cur_col : COL_W'(0);
                sw_ecol <= (mode == ERASE_TO_CUR) ? cur_col : cols_n;
                if (mode != ERASE_RESET) state <= S_SWEEP;
              end
              KIND_READ: begin
                sw_row <= row_clamp;
                sw_col <= col_clamp;
                state  <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_PUT: begin
          cur_col <= cur_col + COL_W'(1);
          state   <= S_DONE;
        end
        S_SWEEP: begin
          if (sw_end) begin
            state <= sw_ret;
          end else if (sw_col >= cols_n) begin
            sw_row <= sw_row + ROW_W'(1);
            sw_col <= '0;
          end else begin
            sw_col <= sw_col + COL_W'(1);
          end
        end
        S_TSTART: state <= S_TMOD;
        S_TMOD: begin
          if (mod_done) begin
            cur_col <= tab_stop;
            state   <= S_TABW;
          end
        end
        S_TABW: state <= S_DONE;
        S_BS0: begin
          if (cur_col == '0 || 9'(cur_col) <= 9'(left_limit)) begin
            state <= S_DONE;
          end else begin
            cur_col <= cur_col - COL_W'(1);
            state   <= S_BS_RD;
          end
        end
        S_BS_RD: state <= S_BS_CHK;
        S_BS_CHK: begin
          if (!tab_rdata) begin
            state <= bs_ret;
          end else begin
            bs_cnt <= '0;
            state  <= S_BS_LP;
          end
        end
        S_BS_LP: begin
          if (bs_cnt == tab_n || cur_col == '0 || 9'(cur_col) == 9'(left_limit)) begin
            state <= bs_ret;
          end else begin
            state <= S_BS_LPC;
          end
        end
        S_BS_LPC: begin
          if (tab_rdata || cell_rdata[7:0] != CH_SPACE) begin
            state <= bs_ret;
          end else begin
            cur_col <= cur_col - COL_W'(1);
            bs_cnt  <= bs_cnt + 5'd1;
            state   <= S_BS_LP;
          end
        end
        S_DW: state <= (cur_col == '0) ? S_DONE : S_DW_C;
        S_DW_C: begin
          if (!dw_two) begin
            if (cell_rdata[7:0] != CH_SPACE) begin
              dw_two <= 1'b1;
              state  <= S_DW;
            end else begin
              state <= S_BS0;
            end
          end else begin
            state <= (cell_rdata[7:0] == CH_SPACE) ? S_DONE : S_BS0;
          end
        end
        S_RD:  state <= S_RDC;
        S_RDC: begin
          cell_val <= cell_rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid        <= 1'b1;
            m_tdata         <= '0;
            m_tdata[4:0]    <= 5'(cur_row);
            m_tdata[12:5]   <= 8'(cur_col);
            m_tdata[13]     <= (view_pos == newest_pos);
            m_tdata[22:14]  <= back_sat;
            m_tdata[38:23]  <= cell_val;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // configuration writes; to be made by the user only while idle, not enforced
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: begin
            vis_rows <= cfg_wdata[5:0];
            base_ok  <= 1'b0;
            if (cur_row > clamp_rows(cfg_wdata[5:0]) - ROW_W'(1)) begin
              cur_row <= clamp_rows(cfg_wdata[5:0]) - ROW_W'(1);
            end
          end
          CFG_COLS: begin
            vis_cols <= cfg_wdata;
            if (cur_col > clamp_cols(cfg_wdata)) cur_col <= clamp_cols(cfg_wdata);
          end
          CFG_TAB:   tab_width <= cfg_wdata[4:0];
          CFG_COLOR: def_color <= cfg_wdata;
        endcase
      end
    end
  end

  // cursor row stays on the screen between items, the column at most one past it
  a_row_in: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur_row < rows_n))
    else $error("cursor row outside screen");

  a_col_in: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur_col <= cols_n))
    else $error("cursor column beyond screen");

  // no store writes while waiting for an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!cell_we && !tab_we))
    else $error("memory write while idle");

  // remainder results only arrive when awaited
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD || state == S_TMOD))
    else $error("unexpected remainder result");

endmodule
